// ===== rtl/rnfe_pkg.sv =====
// Shared types, constants and helper functions of the recurrent network forward-pass core.
`timescale 1ns / 1ps
package rnfe_pkg;

  // Default sizes of the stores.
  localparam int MAX_INPUTS_DEF   = 64;
  localparam int MAX_HIDDEN_DEF   = 32;
  localparam int MAX_OUTPUTS_DEF  = 16;
  localparam int WEIGHT_DEPTH_DEF = 4096;

  // Field and port widths.
  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 12;
  localparam int VALUE_W    = 16;
  localparam int NIDX_W     = 4;
  localparam int NVAL_W     = 32;
  localparam int ERR_W      = 48;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int REC_W      = 15;
  localparam int ACC_W      = 64;

  // Recurrent clamp bounds in Q.12.
  localparam logic signed [31:0] REC_LOW  = -32'sd4096;
  localparam logic signed [31:0] REC_HIGH = 32'sd8192;

  // Network types.
  localparam logic [1:0] NET_ELMAN  = 2'd1;
  localparam logic [1:0] NET_JORDAN = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_INPUT  = 2'd1,
    KIND_EXPECT = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NET_TYPE     = 3'd0,
    REG_INPUT_COUNT  = 3'd1,
    REG_HIDDEN_COUNT = 3'd2,
    REG_OUTPUT_COUNT = 3'd3,
    REG_REC_COUNT    = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L1,
    ST_L1_DRAIN,
    ST_L2,
    ST_L2_DRAIN,
    ST_RUPD,
    ST_ERR,
    ST_ERR_DRAIN,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef enum logic [1:0] {
    SEG_IN,
    SEG_REC,
    SEG_FIN
  } seg_t;

  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_REC,
    SRC_HIDDEN
  } src_t;

  // Control of the recurrent ring of cells.
  typedef struct packed {
    logic clr;
    logic shift;
  } ring_ctl_t;

  // Floor a Q.24 sum to Q.12 and saturate to 32 bits.
  function automatic logic signed [31:0] to_q12(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-13:0] s;
    s = a[ACC_W-1:12];
    if (s > 52'sd2147483647) return 32'sh7fffffff;
    if (s < -52'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Clamp a neuron value into the recurrent range.
  function automatic logic signed [REC_W-1:0] clamp_rec(input logic signed [31:0] v);
    if (v > REC_HIGH) return REC_HIGH[REC_W-1:0];
    if (v < REC_LOW) return REC_LOW[REC_W-1:0];
    return v[REC_W-1:0];
  endfunction

endpackage

// ===== rtl/rnfe_cell.sv =====
// One cell of the recurrent state ring: holds one clamped value and passes it on.
`timescale 1ns / 1ps
module rnfe_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rnfe_pkg::ring_ctl_t                   ctl,
  input  logic signed [rnfe_pkg::REC_W-1:0]     d,
  output logic signed [rnfe_pkg::REC_W-1:0]     q
);

  // Clear on reset or clear item, otherwise take the neighbor's value on a shift.
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/rnfe_div.sv =====
// Bit-serial restoring divider for the mean error, one quotient bit per cycle.
`timescale 1ns / 1ps
module rnfe_div #(
  parameter int DW = 64,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Control: counts the quotient bits still to produce.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend through the remainder, subtracting where it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (run) begin
      rem      <= fits ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

// ===== rtl/recurrent_net_forward_error_core.sv =====
// Top level of the recurrent network forward pass with mean squared error.
//
// Input channel s_*: one item per transfer. s_tuser carries the kind (weight write,
// input element, expected element, clear recurrent state); s_tdata carries the
// index and the Q3.12 value. Load items are taken back to back while idle. The
// expected element at position output_count-1 (output_count capped at MAX_OUTPUTS)
// starts an evaluation, and s_tready stays low until the results are handed to
// the output register. Every weight term of an evaluation passes through a single
// multiply-accumulate pipeline, each recurrent scan walks the whole ring of
// max(MAX_HIDDEN, MAX_OUTPUTS) cells once per neuron, each neuron ends with the end
// of its source walk and a closing step, each layer ends with a pipeline drain, and
// then come the ring reload (Elman or Jordan), the error sum and the mean division.
// Results then leave one at a time whenever the output register is free.
// Output channel m_*: one result per output neuron in order; m_tlast marks the
// final one, which also carries the mean error. A stalled receiver holds the
// output register and the evaluation waits for it.
// Reset clears the configuration to its defaults and the recurrent ring to zero;
// weight, input and expected stores hold nothing until written.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`timescale 1ns / 1ps
module recurrent_net_forward_error_core #(
  parameter int MAX_INPUTS   = rnfe_pkg::MAX_INPUTS_DEF,
  parameter int MAX_HIDDEN   = rnfe_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_OUTPUTS  = rnfe_pkg::MAX_OUTPUTS_DEF,
  parameter int WEIGHT_DEPTH = rnfe_pkg::WEIGHT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: index [11:0], value [27:12], zero fill [31:28]
  input  logic [rnfe_pkg::S_DATA_W-1:0]       s_tdata,
  // tuser: kind [1:0]
  input  logic [rnfe_pkg::KIND_W-1:0]         s_tuser,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata: neuron_index [3:0], neuron_value [35:4], mean_error [83:36], zero fill [87:84]
  output logic [rnfe_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [rnfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rnfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int REC_DEPTH = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS;
  localparam int AW   = $clog2(WEIGHT_DEPTH);
  localparam int IAW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HAW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int OAW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int JMAX = (MAX_INPUTS > REC_DEPTH) ? MAX_INPUTS : REC_DEPTH;
  localparam int JW   = $clog2(JMAX + 1);
  localparam int NW   = $clog2(REC_DEPTH + 1);
  localparam int OW   = $clog2(MAX_OUTPUTS + 1);
  localparam int RW   = rnfe_pkg::REC_W;
  localparam int ACCW = rnfe_pkg::ACC_W;

  // Input fields.
  logic [rnfe_pkg::INDEX_W-1:0]        s_index;
  logic signed [rnfe_pkg::VALUE_W-1:0] s_value;
  logic                                s_xfer;
  assign s_index = s_tdata[11:0];
  assign s_value = s_tdata[27:12];
  assign s_xfer  = s_tvalid && s_tready;

  // Configuration registers.
  logic [1:0] net_mode;
  logic [6:0] input_count;
  logic [5:0] hidden_count;
  logic [4:0] output_count;
  logic [5:0] recurrent_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      net_mode        <= '0;
      input_count     <= 7'd1;
      hidden_count    <= '0;
      output_count    <= 5'd1;
      recurrent_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rnfe_pkg::REG_NET_TYPE:     net_mode        <= cfg_data[1:0];
        rnfe_pkg::REG_INPUT_COUNT:  input_count     <= cfg_data[6:0];
        rnfe_pkg::REG_HIDDEN_COUNT: hidden_count    <= cfg_data[5:0];
        rnfe_pkg::REG_OUTPUT_COUNT: output_count    <= cfg_data[4:0];
        rnfe_pkg::REG_REC_COUNT:    recurrent_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Counts capped at the store sizes, and derived pass controls.
  logic [JW-1:0] ni, nr;
  logic [NW-1:0] nh, nd, n_upd;
  logic [OW-1:0] no;
  logic          elman, jordan, has_hidden, rec1;
  logic [AW-1:0] a_rec_start;

  assign ni = (32'(input_count) > 32'(MAX_INPUTS)) ? JW'(MAX_INPUTS) : JW'(input_count);
  assign nh = (32'(hidden_count) > 32'(MAX_HIDDEN)) ? NW'(MAX_HIDDEN) : NW'(hidden_count);
  assign no = (32'(output_count) > 32'(MAX_OUTPUTS)) ? OW'(MAX_OUTPUTS) : OW'(output_count);
  assign nr = (32'(recurrent_count) > 32'(REC_DEPTH)) ? JW'(REC_DEPTH)
            : JW'(recurrent_count);
  assign elman       = net_mode == rnfe_pkg::NET_ELMAN;
  assign jordan      = net_mode == rnfe_pkg::NET_JORDAN;
  assign has_hidden  = nh != '0;
  assign rec1        = has_hidden ? (elman || jordan) : jordan;
  assign nd          = has_hidden ? nh : NW'(no);
  assign n_upd       = elman ? nh : (jordan ? NW'(no) : '0);
  assign a_rec_start = AW'(32'(nd) * 32'(ni));

  // Sequencer registers.
  rnfe_pkg::state_t state, state_next;
  rnfe_pkg::seg_t   seg;
  logic [JW-1:0]    j;
  logic [NW-1:0]    i;
  logic [NW-1:0]    k;
  logic [AW-1:0]    a_in, a_rec;

  // Stores.
  logic signed [15:0] wmem    [WEIGHT_DEPTH];
  logic signed [15:0] in_mem  [MAX_INPUTS];
  logic signed [15:0] exp_mem [MAX_OUTPUTS];
  logic signed [31:0] hid_mem [MAX_HIDDEN];
  logic signed [31:0] out_mem [MAX_OUTPUTS];
  logic signed [15:0] w_rd, in_rd, exp_rd;
  logic signed [31:0] hid_rd, out_rd;

  // Issue stage controls.
  logic             iss_v, iss_fin, iss_out;
  rnfe_pkg::src_t   iss_src;
  logic [AW-1:0]    iss_waddr;
  logic [HAW-1:0]   hid_ra;
  logic [OAW-1:0]   out_ra;
  logic             trigger, drained, err_drained, out_free, emit_last;
  logic             div_start, div_done;
  logic [63:0]      div_q;

  // Pipeline registers.
  logic                  b_v, b_fin, b_out;
  rnfe_pkg::src_t        b_src;
  logic [NW-1:0]         b_idx;
  logic signed [RW-1:0]  b_rec;
  logic                  c_v, c_fin, c_out;
  logic [NW-1:0]         c_idx;
  logic signed [47:0]    prod;
  logic signed [31:0]    op;
  logic signed [ACCW-1:0] acc;
  logic signed [31:0]    fin_val;

  // Recurrent ring.
  rnfe_pkg::ring_ctl_t   ring_ctl;
  logic signed [RW-1:0]  ring_q [REC_DEPTH];
  logic signed [RW-1:0]  ring_tail;
  logic                  upd_v;

  // Error pipeline.
  logic        e1_v, e2_v, e3_v;
  logic [31:0] m_q;
  logic [63:0] sq_q, err_sum;
  logic signed [32:0] diff;
  logic [64:0] sum_ext;
  logic [rnfe_pkg::ERR_W-1:0] mean;

  // Output register.
  logic [rnfe_pkg::NIDX_W-1:0] o_idx;
  logic signed [31:0]          o_val;
  logic [rnfe_pkg::ERR_W-1:0]  o_err;

  assign trigger = s_xfer && (s_tuser == rnfe_pkg::KIND_EXPECT)
                   && (32'(s_index) < 32'(MAX_OUTPUTS)) && (no != '0)
                   && (32'(s_index) == 32'(no) - 32'd1);
  assign drained     = !b_v && !c_v;
  assign err_drained = !e1_v && !e2_v && !e3_v;
  assign out_free    = !m_tvalid || m_tready;
  assign emit_last   = (32'(k) == 32'(no) - 32'd1);
  assign s_tready    = state == rnfe_pkg::ST_IDLE;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and issue controls.
  always_comb begin
    state_next = state;
    iss_v      = 1'b0;
    iss_fin    = 1'b0;
    iss_src    = rnfe_pkg::SRC_INPUT;
    iss_waddr  = a_in;
    iss_out    = (state == rnfe_pkg::ST_L2) || !has_hidden;
    hid_ra     = j[HAW-1:0];
    out_ra     = k[OAW-1:0];
    ring_ctl.clr   = s_xfer && (s_tuser == rnfe_pkg::KIND_CLEAR);
    ring_ctl.shift = 1'b0;
    ring_tail  = ring_q[0];
    div_start  = 1'b0;
    unique case (state)
      rnfe_pkg::ST_IDLE: begin
        if (trigger) state_next = rnfe_pkg::ST_L1;
      end
      rnfe_pkg::ST_L1: begin
        unique case (seg)
          rnfe_pkg::SEG_IN: begin
            iss_v = j < ni;
          end
          rnfe_pkg::SEG_REC: begin
            ring_ctl.shift = 1'b1;
            iss_v     = j < nr;
            iss_src   = rnfe_pkg::SRC_REC;
            iss_waddr = a_rec;
          end
          rnfe_pkg::SEG_FIN: begin
            iss_v   = 1'b1;
            iss_fin = 1'b1;
            if (i == nd - 1'b1) state_next = rnfe_pkg::ST_L1_DRAIN;
          end
          default: ;
        endcase
      end
      rnfe_pkg::ST_L1_DRAIN: begin
        if (drained) begin
          if (has_hidden) state_next = rnfe_pkg::ST_L2;
          else if (elman || jordan) state_next = rnfe_pkg::ST_RUPD;
          else state_next = rnfe_pkg::ST_ERR;
        end
      end
      rnfe_pkg::ST_L2: begin
        iss_src = rnfe_pkg::SRC_HIDDEN;
        if (seg == rnfe_pkg::SEG_FIN) begin
          iss_v   = 1'b1;
          iss_fin = 1'b1;
          if (i == NW'(no) - 1'b1) state_next = rnfe_pkg::ST_L2_DRAIN;
        end else begin
          iss_v = j < JW'(nh);
        end
      end
      rnfe_pkg::ST_L2_DRAIN: begin
        if (drained) begin
          state_next = (elman || jordan) ? rnfe_pkg::ST_RUPD : rnfe_pkg::ST_ERR;
        end
      end
      rnfe_pkg::ST_RUPD: begin
        hid_ra = k[HAW-1:0];
        if (k != '0) begin
          ring_ctl.shift = 1'b1;
          if (upd_v) ring_tail = rnfe_pkg::clamp_rec(elman ? hid_rd : out_rd);
        end
        if (k == NW'(REC_DEPTH)) state_next = rnfe_pkg::ST_ERR;
      end
      rnfe_pkg::ST_ERR: begin
        if (emit_last) state_next = rnfe_pkg::ST_ERR_DRAIN;
      end
      rnfe_pkg::ST_ERR_DRAIN: begin
        if (err_drained) begin
          div_start  = 1'b1;
          state_next = rnfe_pkg::ST_DIV;
        end
      end
      rnfe_pkg::ST_DIV: begin
        if (div_done) state_next = rnfe_pkg::ST_EMIT_RD;
      end
      rnfe_pkg::ST_EMIT_RD: begin
        state_next = rnfe_pkg::ST_EMIT_LD;
      end
      rnfe_pkg::ST_EMIT_LD: begin
        if (out_free) state_next = emit_last ? rnfe_pkg::ST_IDLE : rnfe_pkg::ST_EMIT_RD;
      end
      default: state_next = rnfe_pkg::ST_IDLE;
    endcase
  end

  // Sequencer counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg   <= rnfe_pkg::SEG_IN;
      j     <= '0;
      i     <= '0;
      k     <= '0;
      a_in  <= '0;
      a_rec <= '0;
      upd_v <= 1'b0;
    end else begin
      upd_v <= 1'b0;
      unique case (state)
        rnfe_pkg::ST_IDLE: begin
          if (trigger) begin
            seg   <= rnfe_pkg::SEG_IN;
            j     <= '0;
            i     <= '0;
            a_in  <= '0;
            a_rec <= a_rec_start;
          end
        end
        rnfe_pkg::ST_L1: begin
          unique case (seg)
            rnfe_pkg::SEG_IN: begin
              if (j < ni) begin
                j    <= j + 1'b1;
                a_in <= a_in + 1'b1;
              end else begin
                j   <= '0;
                seg <= rec1 ? rnfe_pkg::SEG_REC : rnfe_pkg::SEG_FIN;
              end
            end
            rnfe_pkg::SEG_REC: begin
              if (j < nr) a_rec <= a_rec + 1'b1;
              if (j == JW'(REC_DEPTH - 1)) begin
                j   <= '0;
                seg <= rnfe_pkg::SEG_FIN;
              end else begin
                j <= j + 1'b1;
              end
            end
            rnfe_pkg::SEG_FIN: begin
              i   <= i + 1'b1;
              j   <= '0;
              seg <= rnfe_pkg::SEG_IN;
            end
            default: ;
          endcase
        end
        rnfe_pkg::ST_L1_DRAIN: begin
          i   <= '0;
          j   <= '0;
          k   <= '0;
          seg <= rnfe_pkg::SEG_IN;
          if (drained && rec1) a_in <= a_rec;
        end
        rnfe_pkg::ST_L2: begin
          if (seg == rnfe_pkg::SEG_FIN) begin
            i   <= i + 1'b1;
            j   <= '0;
            seg <= rnfe_pkg::SEG_IN;
          end else if (j < JW'(nh)) begin
            j    <= j + 1'b1;
            a_in <= a_in + 1'b1;
          end else begin
            seg <= rnfe_pkg::SEG_FIN;
          end
        end
        rnfe_pkg::ST_L2_DRAIN: begin
          k <= '0;
        end
        rnfe_pkg::ST_RUPD: begin
          upd_v <= k < n_upd;
          k     <= (k == NW'(REC_DEPTH)) ? '0 : k + 1'b1;
        end
        rnfe_pkg::ST_ERR: begin
          k <= emit_last ? '0 : k + 1'b1;
        end
        rnfe_pkg::ST_ERR_DRAIN: ;
        rnfe_pkg::ST_DIV: begin
          k <= '0;
        end
        rnfe_pkg::ST_EMIT_RD: ;
        rnfe_pkg::ST_EMIT_LD: begin
          if (out_free && !emit_last) k <= k + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Store writes from load items, and registered reads.
  always_ff @(posedge clk) begin
    if (s_xfer && s_tuser == rnfe_pkg::KIND_WEIGHT) wmem[AW'(s_index)] <= s_value;
    w_rd <= wmem[iss_waddr];
  end

  always_ff @(posedge clk) begin
    if (s_xfer && s_tuser == rnfe_pkg::KIND_INPUT && 32'(s_index) < 32'(MAX_INPUTS)) begin
      in_mem[s_index[IAW-1:0]] <= s_value;
    end
    in_rd <= in_mem[j[IAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_xfer && s_tuser == rnfe_pkg::KIND_EXPECT && 32'(s_index) < 32'(MAX_OUTPUTS)) begin
      exp_mem[s_index[OAW-1:0]] <= s_value;
    end
    exp_rd <= exp_mem[k[OAW-1:0]];
  end

  // Neuron value stores, written when a neuron closes.
  assign fin_val = rnfe_pkg::to_q12(acc);

  always_ff @(posedge clk) begin
    if (c_v && c_fin && !c_out) hid_mem[c_idx[HAW-1:0]] <= fin_val;
    hid_rd <= hid_mem[hid_ra];
  end

  always_ff @(posedge clk) begin
    if (c_v && c_fin && c_out) out_mem[c_idx[OAW-1:0]] <= fin_val;
    out_rd <= out_mem[out_ra];
  end

  // Multiply-accumulate pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else begin
      b_v <= iss_v;
      c_v <= b_v;
    end
  end

  // Operand select for the multiplier.
  always_comb begin
    unique case (b_src)
      rnfe_pkg::SRC_INPUT:  op = 32'(in_rd);
      rnfe_pkg::SRC_REC:    op = 32'(b_rec);
      rnfe_pkg::SRC_HIDDEN: op = hid_rd;
      default:              op = '0;
    endcase
  end

  // Pipeline payload: operand capture, product, accumulation.
  always_ff @(posedge clk) begin
    b_fin <= iss_fin;
    b_out <= iss_out;
    b_src <= iss_src;
    b_idx <= i;
    b_rec <= ring_q[0];
    c_fin <= b_fin;
    c_out <= b_out;
    c_idx <= b_idx;
    prod  <= w_rd * op;
    if (trigger) begin
      acc <= '0;
    end else if (c_v) begin
      acc <= c_fin ? '0 : acc + ACCW'(prod);
    end
  end

  // Row of recurrent cells, shifting toward cell zero.
  for (genvar c = 0; c < REC_DEPTH; c++) begin : g_ring
    if (c == REC_DEPTH - 1) begin : g_tail
      rnfe_cell u_cell (.clk(clk), .rst(rst), .ctl(ring_ctl), .d(ring_tail), .q(ring_q[c]));
    end else begin : g_body
      rnfe_cell u_cell (.clk(clk), .rst(rst), .ctl(ring_ctl), .d(ring_q[c+1]), .q(ring_q[c]));
    end
  end

  // Squared error pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
    end else begin
      e1_v <= state == rnfe_pkg::ST_ERR;
      e2_v <= e1_v;
      e3_v <= e2_v;
    end
  end

  assign diff    = 33'(out_rd) - 33'(exp_rd);
  assign sum_ext = {1'b0, err_sum} + {1'b0, sq_q};

  // Squared error datapath with a saturating sum.
  always_ff @(posedge clk) begin
    m_q  <= diff[32] ? 32'(-diff) : diff[31:0];
    sq_q <= m_q * m_q;
    if (trigger) begin
      err_sum <= '0;
    end else if (e3_v) begin
      err_sum <= sum_ext[64] ? '1 : sum_ext[63:0];
    end
  end

  rnfe_div #(.DW(64), .VW(OW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (err_sum),
    .divisor  (no),
    .done     (div_done),
    .quotient (div_q)
  );

  // Mean error, floored to Q.12 and saturated.
  always_ff @(posedge clk) begin
    if (div_done) mean <= (div_q[63:60] != '0) ? '1 : div_q[59:12];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rnfe_pkg::ST_EMIT_LD && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rnfe_pkg::ST_EMIT_LD && out_free) begin
      o_idx   <= k[rnfe_pkg::NIDX_W-1:0];
      o_val   <= out_rd;
      o_err   <= emit_last ? mean : '0;
      m_tlast <= emit_last;
    end
  end

  assign m_tdata = {4'b0000, o_err, o_val, o_idx};

endmodule

// ===== tb/tb_recurrent_net_forward_error_core.sv =====
// Self-checking testbench of the recurrent network forward-pass core.
`timescale 1ns / 1ps
module tb_recurrent_net_forward_error_core;

  localparam int WD_LIMIT = 100000;
  localparam int REC_CELLS = 32;

  typedef struct {
    logic [3:0]         nidx;
    logic signed [31:0] nval;
    logic               last;
    logic [47:0]        err;
  } neuron_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [rnfe_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic [rnfe_pkg::KIND_W-1:0] s_tuser = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rnfe_pkg::M_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [rnfe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rnfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow configuration and stores of the network.
  int net_type, n_inputs, n_hidden, n_outputs, n_rec;
  logic signed [15:0] weight_mem [4096];
  bit weight_ok [4096];
  logic signed [15:0] input_mem [64];
  bit input_ok [64];
  logic signed [15:0] target_mem [16];
  bit target_ok [16];
  int hidden_act [32];
  int rec_state [REC_CELLS];
  int weight_ptr;

  neuron_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int evals_done = 0;
  int results_seen = 0;
  bit idle_on = 1'b1;
  int quiet_cycles = 0;

  recurrent_net_forward_error_core i_dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int cap_to(int v, int m);
    return v > m ? m : v;
  endfunction

  function automatic longint next_weight();
    longint w;
    w = longint'(weight_mem[weight_ptr]);
    weight_ptr = (weight_ptr + 1) % 4096;
    return w;
  endfunction

  // Floor a Q.24 sum to Q.12 and saturate to 32 bits.
  function automatic int floor_sat(longint a);
    longint q;
    q = a >>> 12;
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return int'(q);
  endfunction

  function automatic int clamp_state(int v);
    if (v > 8192) return 8192;
    if (v < -4096) return -4096;
    return v;
  endfunction

  // Number of weights that one pass reads with the current settings.
  function automatic int weights_per_pass();
    int ni, nh, no, nr;
    ni = cap_to(n_inputs, 64);
    nh = cap_to(n_hidden, 32);
    no = cap_to(n_outputs, 16);
    nr = cap_to(n_rec, REC_CELLS);
    if (nh > 0)
      return nh * ni + ((net_type == 1 || net_type == 2) ? nh * nr : 0) + no * nh;
    return no * ni + ((net_type == 2) ? no * nr : 0);
  endfunction

  // Forward pass and mean squared error; queues one result per output neuron.
  task automatic compute_pass();
    int ni, nh, no, nr, i, j;
    longint acc [32];
    longint a;
    int outv [16];
    longint d;
    logic [127:0] mag, sq, total, mean;
    neuron_result_t r;
    ni = cap_to(n_inputs, 64);
    nh = cap_to(n_hidden, 32);
    no = cap_to(n_outputs, 16);
    nr = cap_to(n_rec, REC_CELLS);
    weight_ptr = 0;
    if (nh > 0) begin
      for (i = 0; i < nh; i++) begin
        acc[i] = 0;
        for (j = 0; j < ni; j++) acc[i] += next_weight() * longint'(input_mem[j]);
      end
      if (net_type == 1 || net_type == 2)
        for (i = 0; i < nh; i++)
          for (j = 0; j < nr; j++) acc[i] += next_weight() * longint'(rec_state[j]);
      for (i = 0; i < nh; i++) hidden_act[i] = floor_sat(acc[i]);
      for (i = 0; i < no; i++) begin
        a = 0;
        for (j = 0; j < nh; j++) a += next_weight() * longint'(hidden_act[j]);
        outv[i] = floor_sat(a);
      end
    end else begin
      for (i = 0; i < no; i++) begin
        acc[i] = 0;
        for (j = 0; j < ni; j++) acc[i] += next_weight() * longint'(input_mem[j]);
      end
      if (net_type == 2)
        for (i = 0; i < no; i++)
          for (j = 0; j < nr; j++) acc[i] += next_weight() * longint'(rec_state[j]);
      for (i = 0; i < no; i++) outv[i] = floor_sat(acc[i]);
    end
    // Feedback is taken from the hidden layer (Elman) or the outputs (Jordan).
    if (net_type == 1)
      for (i = 0; i < nh; i++) rec_state[i] = clamp_state(hidden_act[i]);
    else if (net_type == 2)
      for (i = 0; i < no; i++) rec_state[i] = clamp_state(outv[i]);
    // Squared error with saturation at 2^64-1.
    total = '0;
    for (i = 0; i < no; i++) begin
      d = longint'(outv[i]) - longint'(target_mem[i]);
      mag = (d < 0) ? 128'(-d) : 128'(d);
      sq = mag * mag;
      total = total + sq;
      if (total > 128'hFFFF_FFFF_FFFF_FFFF) total = 128'hFFFF_FFFF_FFFF_FFFF;
    end
    mean = (total / no) >> 12;
    if (mean > 128'hFFFF_FFFF_FFFF) mean = 128'hFFFF_FFFF_FFFF;
    for (i = 0; i < no; i++) begin
      r.nidx = 4'(i);
      r.nval = outv[i];
      r.last = (i == no - 1);
      r.err = r.last ? mean[47:0] : 48'd0;
      pending_results.push_back(r);
    end
    evals_done++;
  endtask

  // Effect of one accepted item on the shadow state.
  task automatic predict_item(rnfe_pkg::kind_t k, int idx, logic signed [15:0] v);
    int no, i;
    no = cap_to(n_outputs, 16);
    case (k)
      rnfe_pkg::KIND_WEIGHT: begin
        weight_mem[idx] = v;
        weight_ok[idx] = 1'b1;
      end
      rnfe_pkg::KIND_INPUT: begin
        if (idx < 64) begin
          input_mem[idx] = v;
          input_ok[idx] = 1'b1;
        end
      end
      rnfe_pkg::KIND_EXPECT: begin
        if (idx < 16) begin
          target_mem[idx] = v;
          target_ok[idx] = 1'b1;
          if (no > 0 && idx == no - 1) compute_pass();
        end
      end
      default: begin
        for (i = 0; i < REC_CELLS; i++) rec_state[i] = 0;
      end
    endcase
  endtask

  // One input transfer, sometimes with a random idle gap in front of it.
  task automatic send_item(rnfe_pkg::kind_t k, int idx, logic [15:0] v);
    if (idle_on && $urandom_range(0, 99) < 31) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tuser = k;
    s_tdata = {4'b0, v, idx[11:0]};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_item(k, idx, v);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Register write, only while the core has nothing in flight.
  task automatic set_reg(rnfe_pkg::reg_idx_t ri, int v);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = ri;
    cfg_data = v[rnfe_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (ri)
      rnfe_pkg::REG_NET_TYPE:     net_type = v & 3;
      rnfe_pkg::REG_INPUT_COUNT:  n_inputs = v & 127;
      rnfe_pkg::REG_HIDDEN_COUNT: n_hidden = v & 63;
      rnfe_pkg::REG_OUTPUT_COUNT: n_outputs = v & 31;
      rnfe_pkg::REG_REC_COUNT:    n_rec = v & 63;
      default: ;
    endcase
  endtask

  task automatic configure(int t, int ni, int nh, int no, int nr);
    set_reg(rnfe_pkg::REG_NET_TYPE, t);
    set_reg(rnfe_pkg::REG_INPUT_COUNT, ni);
    set_reg(rnfe_pkg::REG_HIDDEN_COUNT, nh);
    set_reg(rnfe_pkg::REG_OUTPUT_COUNT, no);
    set_reg(rnfe_pkg::REG_REC_COUNT, nr);
  endtask

  // Data value biased toward the extremes and toward the clamp range.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4, 5: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  // Loads whatever the pass needs, then the expected vector whose last element
  // starts evaluation. Refresh resends some weights, all inputs and targets.
  task automatic run_pass(bit refresh);
    int nw, ni, no, i;
    nw = weights_per_pass();
    ni = cap_to(n_inputs, 64);
    no = cap_to(n_outputs, 16);
    for (i = 0; i < nw; i++)
      if (!weight_ok[i] || (refresh && $urandom_range(0, 3) == 0))
        send_item(rnfe_pkg::KIND_WEIGHT, i, pick_value());
    for (i = 0; i < ni; i++)
      if (!input_ok[i] || refresh) send_item(rnfe_pkg::KIND_INPUT, i, pick_value());
    for (i = 0; i < no; i++)
      if (i == no - 1 || !target_ok[i] || refresh)
        send_item(rnfe_pkg::KIND_EXPECT, i, pick_value());
  endtask

  // Items that change nothing visible, only the stores or the recurrent state:
  // ignored indexes, far weight addresses, non-final expected elements and clears.
  task automatic send_noise();
    int no;
    no = cap_to(n_outputs, 16);
    case ($urandom_range(0, 4))
      0: send_item(rnfe_pkg::KIND_INPUT, $urandom_range(64, 4095), pick_value());
      1: send_item(rnfe_pkg::KIND_EXPECT, $urandom_range(16, 4095), pick_value());
      2: send_item(rnfe_pkg::KIND_WEIGHT, $urandom_range(3584, 4095), pick_value());
      3: if (no > 1) send_item(rnfe_pkg::KIND_EXPECT, $urandom_range(0, no - 2), pick_value());
      default: send_item(rnfe_pkg::KIND_CLEAR, $urandom_range(0, 4095), pick_value());
    endcase
  endtask

  // Result checker.
  always @(posedge clk) begin
    neuron_result_t e;
    logic [3:0] a_idx;
    logic [31:0] a_val;
    logic [47:0] a_err;
    if (!rst && m_tvalid && m_tready) begin
      a_idx = m_tdata[3:0];
      a_val = m_tdata[35:4];
      a_err = m_tdata[83:36];
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result idx=%0d value=%0d", $realtime, a_idx,
                 $signed(a_val));
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (a_idx !== e.nidx) begin
          $display("%0t: neuron_index expected %0d actual %0d", $realtime, e.nidx, a_idx);
          errors++;
        end
        if (a_val !== e.nval) begin
          $display("%0t: neuron_value expected %0d actual %0d", $realtime, e.nval,
                   $signed(a_val));
          errors++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t: tlast expected %0b actual %0b", $realtime, e.last, m_tlast);
          errors++;
        end
        if (a_err !== e.err) begin
          $display("%0t: mean_error expected %0d actual %0d", $realtime, e.err, a_err);
          errors++;
        end
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    m_tready <= !(idle_on && $urandom_range(0, 99) < 31);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_defaults();
    run_pass(1'b0);
    run_pass(1'b1);
  endtask

  task automatic test_edge_items();
    configure(0, 2, 0, 2, 0);
    send_item(rnfe_pkg::KIND_WEIGHT, 0, 16'h8000);
    send_item(rnfe_pkg::KIND_WEIGHT, 1, 16'h8000);
    send_item(rnfe_pkg::KIND_WEIGHT, 2, 16'h7fff);
    send_item(rnfe_pkg::KIND_WEIGHT, 3, 16'h7fff);
    send_item(rnfe_pkg::KIND_WEIGHT, 4095, 16'hffff);
    send_item(rnfe_pkg::KIND_INPUT, 0, 16'h8000);
    send_item(rnfe_pkg::KIND_INPUT, 1, 16'h7fff);
    send_item(rnfe_pkg::KIND_INPUT, 4095, 16'h1234);
    send_item(rnfe_pkg::KIND_INPUT, 64, 16'h5555);
    send_item(rnfe_pkg::KIND_EXPECT, 16, 16'haaaa);
    send_item(rnfe_pkg::KIND_EXPECT, 4095, 16'h0fff);
    send_item(rnfe_pkg::KIND_EXPECT, 0, 16'h7fff);
    send_item(rnfe_pkg::KIND_EXPECT, 1, 16'h8000);
    send_item(rnfe_pkg::KIND_CLEAR, 4095, 16'hffff);
    // An out-of-range register index must be ignored.
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = 3'd7;
    cfg_data = 7'h7f;
    @(negedge clk);
    cfg_we = 1'b0;
    set_reg(rnfe_pkg::REG_NET_TYPE, 3);
    run_pass(1'b1);
  endtask

  task automatic test_elman();
    int i;
    configure(1, 3, 2, 2, 2);
    for (i = 0; i < 4; i++) run_pass(i == 0);
    send_item(rnfe_pkg::KIND_CLEAR, 0, 16'h0000);
    run_pass(1'b0);
  endtask

  task automatic test_jordan();
    int i;
    configure(2, 2, 0, 3, 3);
    for (i = 0; i < 3; i++) run_pass(1'b1);
    configure(2, 2, 2, 2, 2);
    for (i = 0; i < 3; i++) run_pass(1'b0);
  endtask

  task automatic test_zero_counts();
    configure(0, 0, 2, 1, 0);
    run_pass(1'b0);
    // No outputs: the expected elements start nothing.
    set_reg(rnfe_pkg::REG_OUTPUT_COUNT, 0);
    send_item(rnfe_pkg::KIND_EXPECT, 0, 16'h1111);
    send_item(rnfe_pkg::KIND_EXPECT, 15, 16'h2222);
  endtask

  // Counts above the store sizes, kept small enough to load cheaply.
  task automatic test_oversized();
    configure(0, 1, 0, 31, 0);
    run_pass(1'b0);
    configure(0, 1, 63, 1, 0);
    run_pass(1'b0);
    configure(1, 1, 1, 1, 63);
    run_pass(1'b0);
    run_pass(1'b0);
  endtask

  task automatic test_random();
    int start, k;
    start = items_sent;
    while (items_sent - start < 80) begin
      configure($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 4),
                $urandom_range(1, 4), $urandom_range(0, 5));
      repeat ($urandom_range(1, 4)) begin
        for (k = $urandom_range(0, 3); k > 0; k--) send_noise();
        run_pass($urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    int i;
    net_type = 0; n_inputs = 1; n_hidden = 0; n_outputs = 1; n_rec = 0;
    for (i = 0; i < 4096; i++) weight_ok[i] = 1'b0;
    for (i = 0; i < 64; i++) input_ok[i] = 1'b0;
    for (i = 0; i < 16; i++) target_ok[i] = 1'b0;
    for (i = 0; i < REC_CELLS; i++) rec_state[i] = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_edge_items();
    test_elman();
    test_jordan();
    test_zero_counts();
    // A long stretch with no idling on either side.
    idle_on = 1'b0;
    test_oversized();
    idle_on = 1'b1;
    test_random();
    wait_idle();
    repeat (100) @(negedge clk);
    $display("Covered %0d items and %0d evaluations, %0d results checked.", items_sent,
             evals_done, results_seen);
    $display("Feed forward, Elman and Jordan passes, zero and oversized counts, stalls.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rnfe_pkg.sv
rtl/rnfe_cell.sv
rtl/rnfe_div.sv
rtl/recurrent_net_forward_error_core.sv
tb/tb_recurrent_net_forward_error_core.sv
